// ===== hw/rtl/mdfw_pkg.sv =====
// Shared types and constants of the multiview disparity forward warp unit.
`default_nettype none

package mdfw_pkg;

   // Width of the disparity and key fields of an input word.
   localparam int DISP_BITS = 16;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPARITY_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_COUNT     = 2'd2;

   // Configuration reset values.
   localparam logic [15:0] GAIN_RESET  = 16'd256;
   localparam logic [12:0] WIDTH_RESET = 13'd4096;
   localparam logic [3:0]  VIEWS_RESET = 4'd8;

   // Operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic                        op;
      logic [11:0]                 column;
      logic [2:0]                  view;
      logic signed [DISP_BITS-1:0] shift_disparity;
      logic signed [DISP_BITS-1:0] depth_key;
      logic                        depth_infinite;
      logic [7:0]                  red_in;
      logic [7:0]                  green_in;
      logic [7:0]                  blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       is_hole;
   } rsp_type;

   // One z-buffer entry of one view column.
   typedef struct packed {
      logic signed [DISP_BITS-1:0] key;
      logic [7:0]                  red;
      logic [7:0]                  green;
      logic [7:0]                  blue;
      logic                        hole;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{key: '0, red: '0, green: '0, blue: '0, hole: 1'b1};

endpackage

`default_nettype wire

// ===== hw/rtl/mdfw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module mdfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/multiview_disparity_forward_warp_unit.sv =====
// Forward warp of one image row into up to NUM_VIEWS shifted views, each with its own z-buffer.
// A write word carries a source pixel; its per-view offsets come from one setup multiply
// (disparity times gain) followed by one shared add/subtract unit that steps the product
// one view per cycle, walking up from the center view and then down from it. A write
// passes through accept, multiply, the walk over view_count (clamped to 1..NUM_VIEWS)
// views and a drain of the shift, address and read-modify-write stages; a write that is
// flagged infinite or starts outside the row is dropped when it is accepted.
// A read word waits in ST_RD2 for a free output word and clears the entry it returns.
// All views live in one RAM with one read and one write port.
// After reset the block sweeps all NUM_VIEWS * 2**ceil(log2(MAX_WIDTH)) entries of
// that RAM (32768 at the defaults) back to empty, one entry per cycle, before it takes
// the first word; configuration writes are taken throughout.
`default_nettype none

module multiview_disparity_forward_warp_unit #(
   parameter int NUM_VIEWS = 8,
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire mdfw_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output mdfw_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_write_en,
   input  wire logic [mdfw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [mdfw_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int VW    = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;
   localparam int DEPTH = NUM_VIEWS * (2 ** CW);
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int NVW   = $clog2(NUM_VIEWS + 1);
   localparam int DGW   = mdfw_pkg::DISP_BITS + 17;
   localparam int PW    = DGW + NVW;
   localparam int SW    = PW - 16;
   localparam int NXW   = SW + 1;
   localparam int EW    = $bits(mdfw_pkg::entry_type);
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_WALK,
      ST_DRAIN,
      ST_RD,
      ST_RD2
   } state_type;

   // Configuration registers.
   logic [15:0] disparity_gain_ff;
   logic [12:0] row_width_ff;
   logic [3:0]  view_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disparity_gain_ff <= mdfw_pkg::GAIN_RESET;
         row_width_ff      <= mdfw_pkg::WIDTH_RESET;
         view_count_ff     <= mdfw_pkg::VIEWS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mdfw_pkg::CSR_DISPARITY_GAIN: disparity_gain_ff <= csr_wdata;
            mdfw_pkg::CSR_ROW_WIDTH:      row_width_ff      <= csr_wdata[12:0];
            mdfw_pkg::CSR_VIEW_COUNT:     view_count_ff     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Effective row width and view count, clamped to the store.
   logic [WW-1:0]  width_eff;
   logic [NVW-1:0] nv_eff;
   logic [VW-1:0]  center_v;
   logic [VW-1:0]  top_v;

   always_comb begin
      if (32'(row_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(row_width_ff);
      end
      if (view_count_ff == 4'd0) begin
         nv_eff = NVW'(1);
      end else if (32'(view_count_ff) > 32'(NUM_VIEWS)) begin
         nv_eff = NVW'(NUM_VIEWS);
      end else begin
         nv_eff = NVW'(view_count_ff);
      end
      center_v = VW'(nv_eff >> 1);
      top_v    = VW'(nv_eff - NVW'(1));
   end

   state_type           state_ff;
   mdfw_pkg::req_type   item_ff;
   logic                oob_ff;
   logic [AW-1:0]       clr_ff;
   logic                rsp_vld_ff;
   mdfw_pkg::rsp_type   rsp_data_ff;

   // View walk: generator, shift stage, address stage.
   logic signed [DGW-1:0] dg_ff;
   logic signed [DGW-1:0] dg_in;
   logic signed [PW-1:0]  p_ff;
   logic signed [PW-1:0]  p_ff_in;
   logic [VW-1:0]         v_ff;
   logic                  up_ff;
   logic                  g_vld_ff;
   logic                  b_vld_ff;
   logic [VW-1:0]         b_v_ff;
   logic signed [SW-1:0]  sh_ff;
   logic                  w_vld_ff;
   logic [AW-1:0]         w_addr_ff;

   logic                  at_top;
   logic                  sub_sel;
   logic signed [PW-1:0]  base;
   logic signed [PW-1:0]  dg_ext;
   logic [PW-1:0]         p_round;
   logic signed [NXW-1:0] nx;
   logic                  in_row;
   logic [AW-1:0]         addr_c;
   logic [AW-1:0]         item_addr;

   logic                  skip_write;
   logic                  read_oob;
   logic                  rsp_free;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   mdfw_pkg::entry_type   ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [EW-1:0]         ram_rd_bits;
   mdfw_pkg::entry_type   stored;
   logic                  key_wins;

   assign dg_in = $signed(item_ff.shift_disparity) * $signed({1'b0, disparity_gain_ff});

   // Shared add/subtract: step up from the center, restart below it, step down.
   always_comb begin
      at_top  = (v_ff == top_v);
      sub_sel = !up_ff || at_top;
      base    = (up_ff && at_top) ? '0 : p_ff;
      dg_ext  = PW'(dg_ff);
      p_ff_in = sub_sel ? (base - dg_ext) : (base + dg_ext);
   end

   // Truncate toward zero: bias negative products before the shift.
   assign p_round = p_ff + (p_ff[PW-1] ? PW'(17'h0FFFF) : PW'(0));

   always_comb begin
      nx        = $signed({{(NXW-12){1'b0}}, item_ff.column}) + NXW'(sh_ff);
      in_row    = !nx[NXW-1] && (nx[NXW-2:0] < (NXW-1)'(width_eff));
      addr_c    = AW'({b_v_ff, nx[CW-1:0]});
      item_addr = AW'({VW'(item_ff.view), CW'(item_ff.column)});
   end

   assign skip_write = req_data.depth_infinite
                       || (32'(req_data.column) >= 32'(width_eff));
   assign read_oob   = (32'(req_data.view) >= 32'(NUM_VIEWS))
                       || (32'(req_data.column) >= 32'(MAX_WIDTH));
   assign rsp_free   = !rsp_vld_ff || !rsp_stall;

   assign stored   = mdfw_pkg::entry_type'(ram_rd_bits);
   assign key_wins = item_ff.depth_key > stored.key;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = w_addr_ff;
      ram_wr_data = mdfw_pkg::ENTRY_RESET;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
      end else if (w_vld_ff && key_wins) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = '{key: item_ff.depth_key, red: item_ff.red_in,
                         green: item_ff.green_in, blue: item_ff.blue_in, hole: 1'b0};
      end else if (state_ff == ST_RD2 && rsp_free && !oob_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = item_addr;
      end
      ram_rd_addr = (state_ff == ST_RD || state_ff == ST_RD2) ? item_addr : addr_c;
   end

   mdfw_ram #(
      .WIDTH(EW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(EW'(ram_wr_data)),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         g_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         w_vld_ff   <= 1'b0;
      end else begin
         // Shift and address stages advance every cycle.
         b_vld_ff  <= g_vld_ff;
         b_v_ff    <= v_ff;
         sh_ff     <= $signed(p_round[PW-1:16]);
         w_vld_ff  <= b_vld_ff && in_row;
         w_addr_ff <= addr_c;

         // Drop a taken word unless the read below loads the next one now.
         if (rsp_vld_ff && !rsp_stall && state_ff != ST_RD2) begin
            rsp_vld_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == CLR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  oob_ff  <= read_oob;
                  if (req_data.op == mdfw_pkg::OP_READ) begin
                     state_ff <= ST_RD;
                  end else if (!skip_write) begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               dg_ff    <= dg_in;
               v_ff     <= center_v;
               p_ff     <= '0;
               up_ff    <= 1'b1;
               g_vld_ff <= 1'b1;
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               if (up_ff && !at_top) begin
                  v_ff <= v_ff + VW'(1);
                  p_ff <= p_ff_in;
               end else if (up_ff && center_v != '0) begin
                  v_ff  <= center_v - VW'(1);
                  p_ff  <= p_ff_in;
                  up_ff <= 1'b0;
               end else if (!up_ff && v_ff != '0) begin
                  v_ff <= v_ff - VW'(1);
                  p_ff <= p_ff_in;
               end else begin
                  g_vld_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!b_vld_ff && !w_vld_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RD: begin
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               // Hold the read until the output word is free.
               if (rsp_free) begin
                  rsp_vld_ff <= 1'b1;
                  if (oob_ff) begin
                     rsp_data_ff <= '{red_out: '0, green_out: '0, blue_out: '0,
                                      is_hole: 1'b1};
                  end else begin
                     rsp_data_ff <= '{red_out: stored.red, green_out: stored.green,
                                      blue_out: stored.blue, is_hole: stored.hole};
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
